// File: rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Shared constants, command and status codes, and request, response and
// table entry and free stack entry types.
// ----------------------------------------------------------------------------
package gha_pkg;

	localparam int SLOTS   = 1024;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int IDX_W   = 10;
	localparam int GEN_W   = 16;

	localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
	localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);
	localparam logic [GEN_W-1:0] GEN_MAX   = {GEN_W{1'b1}};

	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_DESTROY = 2'd1;
	localparam logic [1:0] CMD_CHECK   = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DEAD = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [IDX_W-1:0] slot_index;
		logic [GEN_W-1:0] slot_generation;
	} gha_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] handle_index;
		logic [GEN_W-1:0] handle_generation;
		logic [1:0]       status;
	} gha_rsp_t;

	typedef struct packed {
		logic             alive;
		logic [GEN_W-1:0] gen;
	} gha_entry_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  gen;
	} gha_free_t;

	function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] gen);
		return (gen == GEN_MAX) ? GEN_FIRST : gen + GEN_FIRST;
	endfunction

endpackage

// File: rtl/gha_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/gha_result_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one response until the receiver takes it and reports when it can
// be loaded with the next one.
// ----------------------------------------------------------------------------
module gha_result_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  gha_pkg::gha_rsp_t load_data,
	output logic              ready,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output gha_pkg::gha_rsp_t rsp
);
	import gha_pkg::*;

	logic     valid_q;
	gha_rsp_t data_q;

	assign ready     = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			data_q <= load_data;
		end
	end

endmodule

// File: rtl/generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// Generational handle allocator
// Allocates, frees and checks handles made of a slot index and a generation.
// ----------------------------------------------------------------------------
// A request arrives on req with req_valid and is taken at a clock edge where
// req_stall is low. A create returns a new handle, reusing the most recently
// freed slot first, or reports full when no slot is left. A destroy frees a
// live handle and advances its generation. A check reports whether a handle is still live.
// Every request gives exactly one response on rsp with rsp_valid, taken at an
// edge where rsp_stall is low. The edge that takes a request also starts the
// synchronous read of the slot table and the free stack; the first edge
// after that at which the result register is ready writes the update and
// loads the result register, from which the response is valid.
// A new request is taken in every cycle unless req_stall is high; a write
// followed at once by a read of the same entry is served by a bypass register.
// Reset clears the free count and the used count, so the block starts empty
// with no clearing pass. When the receiver stalls, the result register holds
// its response, one more request may sit in the read stage, and req_stall
// rises once both are occupied.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  gha_pkg::gha_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output gha_pkg::gha_rsp_t rsp
);
	import gha_pkg::*;

	logic              v_s1;
	gha_req_t          req_s1;
	logic              tfwd_s1;
	gha_entry_t        tfwd_data_s1;
	logic              sfwd_s1;
	gha_free_t         sfwd_data_s1;
	logic [CNT_W-1:0]  free_cnt_q;
	logic [CNT_W-1:0]  used_q;

	logic              rsp_ready;
	logic              adv;
	logic              acc;
	gha_entry_t        tab_rdata;
	gha_free_t         stk_rdata;
	gha_entry_t        tab_e;
	gha_free_t         stk_e;
	logic              live;
	logic [SLOT_W-1:0] idx_s1;

	logic              tab_we;
	logic [SLOT_W-1:0] tab_waddr;
	gha_entry_t        tab_wdata;
	logic              stk_we;
	logic [SLOT_W-1:0] stk_waddr;
	gha_free_t         stk_wdata;
	logic [SLOT_W-1:0] tab_raddr;
	logic [SLOT_W-1:0] stk_raddr;
	logic              push;
	logic              pop;
	logic              fresh;
	logic [CNT_W-1:0]  free_cnt_nx;
	logic [CNT_W-1:0]  stk_top;
	gha_rsp_t          rsp_nx;
	logic [GEN_W-1:0]  gen_adv;

	assign adv       = v_s1 && rsp_ready;
	assign req_stall = v_s1 && !adv;
	assign acc       = req_valid && !req_stall;

	assign tab_e  = tfwd_s1 ? tfwd_data_s1 : tab_rdata;
	assign stk_e  = sfwd_s1 ? sfwd_data_s1 : stk_rdata;
	assign idx_s1 = SLOT_W'(req_s1.slot_index);
	assign live   = (CNT_W'(req_s1.slot_index) < used_q) && tab_e.alive
		&& (tab_e.gen == req_s1.slot_generation);
	assign gen_adv = next_gen(tab_e.gen);

	always_comb begin
		rsp_nx    = '0;
		rsp_nx.status = ST_OK;
		tab_we    = 1'b0;
		tab_waddr = idx_s1;
		tab_wdata = '0;
		stk_we    = 1'b0;
		stk_waddr = free_cnt_q[SLOT_W-1:0];
		stk_wdata = '0;
		push      = 1'b0;
		pop       = 1'b0;
		fresh     = 1'b0;
		case (req_s1.cmd)
			CMD_CREATE: begin
				if (free_cnt_q != '0) begin
					pop       = 1'b1;
					tab_we    = 1'b1;
					tab_waddr = stk_e.slot;
					tab_wdata = '{alive: 1'b1, gen: stk_e.gen};
					rsp_nx.handle_index      = IDX_W'(stk_e.slot);
					rsp_nx.handle_generation = stk_e.gen;
				end else if (used_q < SLOTS_CNT) begin
					fresh     = 1'b1;
					tab_we    = 1'b1;
					tab_waddr = used_q[SLOT_W-1:0];
					tab_wdata = '{alive: 1'b1, gen: GEN_FIRST};
					rsp_nx.handle_index      = IDX_W'(used_q[SLOT_W-1:0]);
					rsp_nx.handle_generation = GEN_FIRST;
				end else begin
					rsp_nx.status = ST_FULL;
				end
			end
			CMD_DESTROY: begin
				if (live && (free_cnt_q < SLOTS_CNT)) begin
					push      = 1'b1;
					tab_we    = 1'b1;
					tab_wdata = '{alive: 1'b0, gen: gen_adv};
					stk_we    = 1'b1;
					stk_wdata = '{slot: idx_s1, gen: gen_adv};
				end else begin
					rsp_nx.status = ST_DEAD;
				end
			end
			default: begin
				rsp_nx.status = live ? ST_OK : ST_DEAD;
			end
		endcase
		tab_we = tab_we && adv;
		stk_we = stk_we && adv;
		push   = push && adv;
		pop    = pop && adv;
		fresh  = fresh && adv;
	end

	assign free_cnt_nx = free_cnt_q + CNT_W'(push) - CNT_W'(pop);
	assign stk_top     = free_cnt_nx - CNT_W'(1);
	assign stk_raddr   = stk_top[SLOT_W-1:0];
	assign tab_raddr   = SLOT_W'(req.slot_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			free_cnt_q <= '0;
			used_q     <= '0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			free_cnt_q <= free_cnt_nx;
			used_q     <= used_q + CNT_W'(fresh);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1       <= req;
			tfwd_s1      <= tab_we && (tab_waddr == tab_raddr);
			tfwd_data_s1 <= tab_wdata;
			sfwd_s1      <= stk_we && (stk_waddr == stk_raddr);
			sfwd_data_s1 <= stk_wdata;
		end
	end

	gha_ram #(
		.WIDTH($bits(gha_entry_t)),
		.DEPTH(SLOTS)
	) u_slot_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.re    (acc),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	gha_ram #(
		.WIDTH($bits(gha_free_t)),
		.DEPTH(SLOTS)
	) u_free_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (acc),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	gha_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (v_s1),
		.load_data (rsp_nx),
		.ready     (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
